// ===== hdl/bba_pkg.sv =====
// package for the buddy block allocator: field widths, default parameters,
// status and command codes, sequencer states, unit grid helper; no dependencies
`timescale 1ns / 1ps
package bba_pkg;

	localparam int HEAP_LOG2_DEF   = 16;
	localparam int MIN_BLOCK_DEF   = 16;
	localparam int HEADER_DEF      = 8;

	localparam int ORD_W  = 5;   // block order
	localparam int ADDR_W = 16;  // address and byte count fields
	localparam int CNT_W  = 17;  // bytes used fields
	localparam int SIZE_W = 18;  // rounded request size compare
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOBLK = 2'd1;
	localparam logic [STAT_W-1:0] ST_NULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_AK, S_ASRCH, S_ASPLIT, S_AFIN,
		S_DRD, S_DCHK, S_DMRG, S_DMRD, S_DMCHK,
		S_U1, S_U2, S_P1, S_P2, S_DONE
	} bba_state_t;

	// log2 of the unit grid: minimum block rounded up to a power of two, at least 8, at most 64
	function automatic int unit_log2(input int min_bytes);
		int r;
		if (min_bytes <= 8) r = 3;
		else if (min_bytes <= 16) r = 4;
		else if (min_bytes <= 32) r = 5;
		else r = 6;
		return r;
	endfunction

endpackage

// ===== hdl/buddy_block_allocator.sv =====
// binary buddy allocator top level: sequencer, unit header and link memories,
// free list heads; depends on bba_pkg
`timescale 1ns / 1ps
// allocate: round the size up to order k, search upward from k for a free block,
//   unlink it and split it down to k; free: read and check the header, merge with each
//   free buddy level by level, then push the result; rejects go straight to done
// items are handled one at a time; a held result stalls input
// reset and every max_log2 write run a clearing pass over the unit memories;
//   no item is taken meanwhile
module buddy_block_allocator #(
	parameter int HEAP_LOG2       = bba_pkg::HEAP_LOG2_DEF,
	parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_DEF,
	parameter int HEADER_BYTES    = bba_pkg::HEADER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,     // max_log2
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // byte_count[15:0], body_address[31:16]
	input  logic        s_tuser,      // command
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], granted_address[17:2], bytes_used[34:18], peak_bytes_used[51:35]
	output logic [55:0] m_tdata
);
	import bba_pkg::*;

	localparam int UL     = unit_log2(MIN_BLOCK_BYTES);
	localparam int UW     = HEAP_LOG2 - UL;            // unit index bits
	localparam int NU     = 1 << UW;                   // unit count
	localparam int LEVELS = HEAP_LOG2 + 1;
	localparam int LW     = $clog2(LEVELS);
	localparam int AW     = (HEAP_LOG2 > 16) ? HEAP_LOG2 + 1 : 17;
	localparam logic [ORD_W-1:0] HEAP_RST = ORD_W'((16 < UL) ? UL :
		(16 > HEAP_LOG2) ? HEAP_LOG2 : 16);

	// state
	bba_state_t state_q, state_d;
	logic [ORD_W-1:0] heap_q;
	logic [UW-1:0]    clr_q, u_q, b_q;
	logic [ORD_W-1:0] ord_q, k_q;
	logic [SIZE_W-1:0] size_q;
	logic             cmd_q;
	logic [STAT_W-1:0] st_q;
	logic [AW-1:0]    gr_q, used_q, peak_q;
	logic [UW:0]      head_q [LEVELS];   // {valid, unit}
	logic             m_tvalid_q;
	logic [55:0]      m_tdata_q;

	// memories: header {free, order}, next and prev links {valid, unit}
	logic [ORD_W:0] hdr_mem [NU];
	logic [UW:0]    nx_mem  [NU];
	logic [UW:0]    pv_mem  [NU];
	logic [ORD_W:0] hdr_rd_q;
	logic [UW:0]    nx_rd_q, pv_rd_q;
	logic [UW-1:0]  hdr_ra;

	logic           hdr_we, nx_we, pv_we;
	logic [UW-1:0]  hdr_wa, nx_wa, pv_wa;
	logic [ORD_W:0] hdr_wd;
	logic [UW:0]    nx_wd, pv_wd;

	logic [UW:0]    head_cur;
	logic           in_acc, cfg_acc;
	logic [ORD_W-1:0] cfg_heap;

	// input decode
	logic [ADDR_W-1:0] cnt_in, addr_in, off_in;
	logic [SIZE_W-1:0] size_raw, size_in;
	logic [AW-1:0]     off_w;
	logic              free_bad;

	// header check
	logic [ORD_W-1:0] r_ord;
	logic             r_free;
	logic [UW-1:0]    dmask;
	logic             dchk_bad;
	logic [AW-1:0]    used_add;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid;
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign cfg_heap = (cfg_data < ORD_W'(UL)) ? ORD_W'(UL) :
		(cfg_data > ORD_W'(HEAP_LOG2)) ? ORD_W'(HEAP_LOG2) : cfg_data;

	assign head_cur = head_q[ord_q[LW-1:0]];

	assign cnt_in   = s_tdata[15:0];
	assign addr_in  = s_tdata[31:16];
	assign size_raw = SIZE_W'(cnt_in) + SIZE_W'(HEADER_BYTES);
	assign size_in  = (size_raw < SIZE_W'(MIN_BLOCK_BYTES)) ? SIZE_W'(MIN_BLOCK_BYTES) : size_raw;
	assign off_in   = addr_in - ADDR_W'(HEADER_BYTES);
	assign off_w    = AW'(off_in);
	// offset off the unit grid or beyond the heap
	assign free_bad = (off_w[UL-1:0] != '0) || (off_w >= (AW'(1) << heap_q));

	assign r_ord    = hdr_rd_q[ORD_W-1:0];
	assign r_free   = hdr_rd_q[ORD_W];
	assign dmask    = (UW'(1) << (r_ord - ORD_W'(UL))) - UW'(1);
	// not a reserved block start of a legal order
	assign dchk_bad = r_free || (r_ord < ORD_W'(UL)) || (r_ord > heap_q) ||
		((u_q & dmask) != '0);
	assign used_add = used_q + (AW'(1) << k_q);

	assign hdr_ra = (state_q == S_DRD) ? u_q : b_q;

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
		if (nx_we) nx_mem[nx_wa] <= nx_wd;
		if (pv_we) pv_mem[pv_wa] <= pv_wd;
		hdr_rd_q <= hdr_mem[hdr_ra];
		nx_rd_q  <= nx_mem[b_q];
		pv_rd_q  <= pv_mem[b_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else if (cfg_acc) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory write strobes
	always_comb begin
		state_d = state_q;
		hdr_we = 1'b0; hdr_wa = b_q; hdr_wd = {1'b1, ord_q};
		nx_we  = 1'b0; nx_wa  = b_q; nx_wd  = head_cur;
		pv_we  = 1'b0; pv_wa  = b_q; pv_wd  = '0;
		case (state_q)
			S_CLR: begin
				hdr_we = 1'b1; hdr_wa = clr_q;
				hdr_wd = (clr_q == '0) ? {1'b1, heap_q} : {1'b1, ORD_W'(0)};
				nx_we = 1'b1; nx_wa = clr_q; nx_wd = '0;
				pv_we = 1'b1; pv_wa = clr_q;
				if (clr_q == UW'(NU - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					if (s_tuser == CMD_ALLOC) begin
						state_d = (cnt_in == '0) ? S_DONE : S_AK;
					end else begin
						state_d = (addr_in == '0 || addr_in < ADDR_W'(HEADER_BYTES) ||
							free_bad) ? S_DONE : S_DRD;
					end
				end
			end
			S_AK: begin
				if (!((SIZE_W'(1) << k_q) < size_q)) state_d = S_ASRCH;
			end
			S_ASRCH: begin
				if (ord_q > heap_q) state_d = S_DONE;
				else if (head_cur[UW]) state_d = S_U1;
			end
			S_U1: state_d = S_U2;
			S_U2: begin
				// unlink: predecessor or head takes next, successor takes prev
				if (pv_rd_q[UW]) begin
					nx_we = 1'b1; nx_wa = pv_rd_q[UW-1:0]; nx_wd = nx_rd_q;
				end
				if (nx_rd_q[UW]) begin
					pv_we = 1'b1; pv_wa = nx_rd_q[UW-1:0]; pv_wd = pv_rd_q;
				end
				state_d = (cmd_q == CMD_ALLOC) ? S_ASPLIT : S_DMRG;
			end
			S_ASPLIT: state_d = (ord_q > k_q) ? S_P1 : S_AFIN;
			S_AFIN: begin
				hdr_we = 1'b1; hdr_wa = u_q; hdr_wd = {1'b0, k_q};
				state_d = S_DONE;
			end
			S_P1: begin
				hdr_we = 1'b1;
				nx_we  = 1'b1;
				pv_we  = 1'b1;
				state_d = S_P2;
			end
			S_P2: begin
				if (head_cur[UW]) begin
					pv_we = 1'b1; pv_wa = head_cur[UW-1:0]; pv_wd = {1'b1, b_q};
				end
				state_d = (cmd_q == CMD_ALLOC) ? S_ASPLIT : S_DONE;
			end
			S_DRD: state_d = S_DCHK;
			S_DCHK: begin
				if (dchk_bad) begin
					state_d = S_DONE;
				end else begin
					hdr_we = 1'b1; hdr_wa = u_q; hdr_wd = {1'b1, r_ord};
					state_d = S_DMRG;
				end
			end
			S_DMRG: state_d = (ord_q < heap_q) ? S_DMRD : S_P1;
			S_DMRD: state_d = S_DMCHK;
			S_DMCHK: state_d = (!r_free || r_ord != ord_q) ? S_P1 : S_U1;
			S_DONE: if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= HEAP_RST;
			clr_q  <= '0;
			used_q <= '0;
			peak_q <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++)
				head_q[i] <= (i == int'(HEAP_RST)) ? {1'b1, UW'(0)} : '0;
		end else if (cfg_acc) begin
			heap_q <= cfg_heap;
			clr_q  <= '0;
			used_q <= '0;
			peak_q <= '0;
			for (int i = 0; i < LEVELS; i++)
				head_q[i] <= (i == int'(cfg_heap)) ? {1'b1, UW'(0)} : '0;
		end else begin
			// result taken; the done state reloads it below
			if (m_tready && state_q != S_DONE) m_tvalid_q <= 1'b0;
			case (state_q)
				S_CLR: clr_q <= clr_q + UW'(1);
				S_IDLE: begin
					if (in_acc) begin
						cmd_q  <= s_tuser;
						gr_q   <= '0;
						st_q   <= ST_OK;
						size_q <= size_in;
						k_q    <= ORD_W'(UL);
						u_q    <= off_w[HEAP_LOG2-1:UL];
						if (s_tuser == CMD_ALLOC) begin
							if (cnt_in == '0) st_q <= ST_BAD;
						end else if (addr_in == '0) begin
							st_q <= ST_NULL;
						end else if (addr_in < ADDR_W'(HEADER_BYTES) || free_bad) begin
							st_q <= ST_BAD;
						end
					end
				end
				S_AK: begin
					if ((SIZE_W'(1) << k_q) < size_q) k_q <= k_q + ORD_W'(1);
					else ord_q <= k_q;
				end
				S_ASRCH: begin
					if (ord_q > heap_q) begin
						st_q <= ST_NOBLK;
					end else if (head_cur[UW]) begin
						u_q <= head_cur[UW-1:0];
						b_q <= head_cur[UW-1:0];
					end else begin
						ord_q <= ord_q + ORD_W'(1);
					end
				end
				S_U2: begin
					if (!pv_rd_q[UW]) head_q[ord_q[LW-1:0]] <= nx_rd_q;
					if (cmd_q == CMD_FREE) begin
						if (b_q < u_q) u_q <= b_q;
						ord_q <= ord_q + ORD_W'(1);
					end
				end
				S_ASPLIT: begin
					if (ord_q > k_q) begin
						ord_q <= ord_q - ORD_W'(1);
						b_q <= u_q ^ (UW'(1) << (ord_q - ORD_W'(1) - ORD_W'(UL)));
					end
				end
				S_AFIN: begin
					used_q <= used_add;
					if (used_add > peak_q) peak_q <= used_add;
					gr_q <= (AW'(u_q) << UL) + AW'(HEADER_BYTES);
				end
				S_P2: head_q[ord_q[LW-1:0]] <= {1'b1, b_q};
				S_DCHK: begin
					if (dchk_bad) begin
						st_q <= ST_BAD;
					end else begin
						used_q <= used_q - (AW'(1) << r_ord);
						ord_q <= r_ord;
					end
				end
				S_DMRG: begin
					if (ord_q < heap_q) b_q <= u_q ^ (UW'(1) << (ord_q - ORD_W'(UL)));
					else b_q <= u_q;
				end
				S_DMCHK: begin
					if (!r_free || r_ord != ord_q) b_q <= u_q;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {4'b0, peak_q[CNT_W-1:0], used_q[CNT_W-1:0],
							gr_q[ADDR_W-1:0], st_q};
					end
				end
				default: ;
			endcase
		end
	end

	// checks
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= peak_q) else $error("bytes used above peak");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !cfg_acc |=> !s_tready) else $error("item taken while busy");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> state_q == S_CLR) else $error("config write did not clear heap");
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17:2] != 16'd0 |-> m_tdata[1:0] == ST_OK)
		else $error("address granted with bad status");

endmodule
